// ===== hw/rtl/ppa_pkg.sv =====
`timescale 1ns / 1ps
package ppa_pkg;

	// fixed field widths
	localparam int PAGE_W = 12;
	localparam int CNT_W  = 13;
	localparam int REQ_W  = 3;

	localparam logic [CNT_W-1:0] RESERVE_RESET = 13'd32;

	// raw request codes on the req_type port
	localparam logic [REQ_W-1:0] REQ_ADD    = 3'd0;
	localparam logic [REQ_W-1:0] REQ_BUILD  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_ALLOC  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_FREE   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_CONTIG = 3'd4;

	typedef enum logic [2:0] {
		OP_ADD,
		OP_BUILD,
		OP_ALLOC,
		OP_FREE,
		OP_CONTIG,
		OP_BAD
	} op_t;

	typedef enum logic [2:0] {
		STAT_OK       = 3'd0,
		STAT_OOM      = 3'd1,
		STAT_NOFIT    = 3'd2,
		STAT_NOTREADY = 3'd3,
		STAT_BAD      = 3'd4
	} stat_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_PG_CHK,
		S_POP,
		S_SCAN,
		S_BUILD,
		S_CSCAN,
		S_CCLR,
		S_CMP,
		S_RESULT
	} st_t;

	// classified request, front to back
	typedef struct packed {
		op_t               op;
		logic [PAGE_W-1:0] page;
		logic              oob;
		logic [CNT_W-1:0]  page_count;
		logic [CNT_W-1:0]  min_page;
		logic [CNT_W-1:0]  max_page;
		logic [CNT_W-1:0]  boundary_pages;
	} req_t;

	typedef struct packed {
		logic [PAGE_W-1:0] page_res;
		stat_t             status;
		logic              evict_request;
		logic              cache_normal;
		logic [CNT_W-1:0]  free_pages;
		logic [CNT_W-1:0]  known_pages;
	} res_t;

endpackage

// ===== hw/rtl/ppa_ram.sv =====
`timescale 1ns / 1ps
module ppa_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/ppa_fifo.sv =====
`timescale 1ns / 1ps
module ppa_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [NW-1:0]    fill_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (fill_q == NW'(DEPTH));
	assign empty   = (fill_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/ppa_front.sv =====
`timescale 1ns / 1ps
module ppa_front #(
	parameter int NUM_PAGES = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [ppa_pkg::REQ_W-1:0]  req_type,
	input  logic [ppa_pkg::PAGE_W-1:0] page,
	input  logic [ppa_pkg::CNT_W-1:0]  page_count,
	input  logic [ppa_pkg::CNT_W-1:0]  min_page,
	input  logic [ppa_pkg::CNT_W-1:0]  max_page,
	input  logic [ppa_pkg::CNT_W-1:0]  boundary_pages,
	input  logic                       init_done,
	input  logic                       rq_pop,
	output logic                       rq_empty,
	output ppa_pkg::req_t              rq_head
);

	localparam int CW = $clog2(NUM_PAGES + 1);
	localparam int EW = ((CW > ppa_pkg::CNT_W) ? CW : ppa_pkg::CNT_W) + 2;

	typedef logic [EW-1:0] ext_t;

	ppa_pkg::req_t                    req_in;
	logic                             q_full;
	logic [$bits(ppa_pkg::req_t)-1:0] q_rdata;

	// decode and range check
	always_comb begin
		req_in                = '0;
		req_in.page           = page;
		req_in.oob            = (ext_t'(page) >= ext_t'(NUM_PAGES));
		req_in.page_count     = page_count;
		req_in.min_page       = min_page;
		req_in.max_page       = max_page;
		req_in.boundary_pages = boundary_pages;
		case (req_type)
			ppa_pkg::REQ_ADD:    req_in.op = ppa_pkg::OP_ADD;
			ppa_pkg::REQ_BUILD:  req_in.op = ppa_pkg::OP_BUILD;
			ppa_pkg::REQ_ALLOC:  req_in.op = ppa_pkg::OP_ALLOC;
			ppa_pkg::REQ_FREE:   req_in.op = ppa_pkg::OP_FREE;
			ppa_pkg::REQ_CONTIG: req_in.op = ppa_pkg::OP_CONTIG;
			default:             req_in.op = ppa_pkg::OP_BAD;
		endcase
	end

	// held off while the bitmap is being cleared
	assign full = q_full || !init_done;

	ppa_fifo #(
		.WIDTH($bits(ppa_pkg::req_t)),
		.DEPTH(2)
	) u_req_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push && !full),
		.wdata (req_in),
		.full  (q_full),
		.pop   (rq_pop),
		.rdata (q_rdata),
		.empty (rq_empty)
	);

	assign rq_head = q_rdata;

endmodule

// ===== hw/rtl/ppa_back.sv =====
`timescale 1ns / 1ps
module ppa_back #(
	parameter int NUM_PAGES = 4096
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [ppa_pkg::CNT_W-1:0] emergency,
	input  logic                      rq_empty,
	input  ppa_pkg::req_t             rq_head,
	output logic                      rq_pop,
	input  logic                      out_full,
	output logic                      out_push,
	output ppa_pkg::res_t             out_data,
	output logic                      init_done
);

	localparam int PW = $clog2(NUM_PAGES);
	localparam int CW = $clog2(NUM_PAGES + 1);
	localparam int EW = ((CW > ppa_pkg::CNT_W) ? CW : ppa_pkg::CNT_W) + 2;
	localparam int NW = ppa_pkg::CNT_W;

	typedef logic [PW-1:0] pidx_t;
	typedef logic [CW-1:0] cnt_t;
	typedef logic [EW-1:0] ext_t;
	typedef logic [NW-1:0] num_t;

	ppa_pkg::st_t  state_q, state_d;
	ppa_pkg::req_t cur_q, cur_d;
	cnt_t          scan_q, scan_d;
	logic          vld_s1, vld_d;
	cnt_t          idx_s1, idx_d;
	num_t          mod_q, mod_d;
	num_t          mod_s1, mod1_d;
	cnt_t          run_q, run_d;
	cnt_t          top_q, top_d;
	pidx_t         start_q, start_d;
	pidx_t         end_q, end_d;
	cnt_t          wr_q, wr_d;
	cnt_t          depth_q, depth_d;
	cnt_t          free_q, free_d;
	cnt_t          known_q, known_d;
	pidx_t         high_q, high_d;
	logic          ready_q, ready_d;
	logic [ppa_pkg::PAGE_W-1:0] res_page_q, res_page_d;
	ppa_pkg::stat_t             res_stat_q, res_stat_d;
	logic          res_evict_q, res_evict_d;
	logic          res_cache_q, res_cache_d;

	// memory ports
	logic  bm_we, bm_wdata, bm_rdata;
	pidx_t bm_waddr, bm_raddr;
	logic  sk_we;
	pidx_t sk_waddr, sk_raddr, sk_wdata, sk_rdata;

	logic issue;
	logic okbit;
	ext_t top_raw;
	ext_t run_start;

	// free bitmap and free stack
	ppa_ram #(.WIDTH(1), .DEPTH(NUM_PAGES)) u_bitmap (
		.clk(clk), .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
		.raddr(bm_raddr), .rdata(bm_rdata)
	);

	ppa_ram #(.WIDTH(PW), .DEPTH(NUM_PAGES)) u_stack (
		.clk(clk), .we(sk_we), .waddr(sk_waddr), .wdata(sk_wdata),
		.raddr(sk_raddr), .rdata(sk_rdata)
	);

	// upper scan limit for a contiguous request, clamped to the array
	assign top_raw = (rq_head.max_page == '0) ? ext_t'(high_q) + 1'b1
		: ext_t'(rq_head.max_page);
	assign run_start = ext_t'(idx_s1) + 1'b1 - ext_t'(cur_q.page_count);

	assign init_done = (state_q != ppa_pkg::S_CLEAR);

	always_comb begin
		out_data               = '0;
		out_data.page_res      = res_page_q;
		out_data.status        = res_stat_q;
		out_data.evict_request = res_evict_q;
		out_data.cache_normal  = res_cache_q;
		out_data.free_pages    = ppa_pkg::CNT_W'(free_q);
		out_data.known_pages   = ppa_pkg::CNT_W'(known_q);
	end

	// sequencer
	always_comb begin
		state_d     = state_q;
		cur_d       = cur_q;
		scan_d      = scan_q;
		vld_d       = vld_s1;
		idx_d       = idx_s1;
		mod_d       = mod_q;
		mod1_d      = mod_s1;
		run_d       = run_q;
		top_d       = top_q;
		start_d     = start_q;
		end_d       = end_q;
		wr_d        = wr_q;
		depth_d     = depth_q;
		free_d      = free_q;
		known_d     = known_q;
		high_d      = high_q;
		ready_d     = ready_q;
		res_page_d  = res_page_q;
		res_stat_d  = res_stat_q;
		res_evict_d = res_evict_q;
		res_cache_d = res_cache_q;
		bm_we       = 1'b0;
		bm_waddr    = '0;
		bm_wdata    = 1'b0;
		bm_raddr    = '0;
		sk_we       = 1'b0;
		sk_waddr    = '0;
		sk_wdata    = '0;
		sk_raddr    = '0;
		rq_pop      = 1'b0;
		out_push    = 1'b0;
		issue       = 1'b0;
		okbit       = 1'b0;

		case (state_q)
			// clearing pass over the bitmap after reset
			ppa_pkg::S_CLEAR: begin
				bm_we    = 1'b1;
				bm_waddr = pidx_t'(scan_q);
				scan_d   = scan_q + 1'b1;
				if (scan_q == cnt_t'(NUM_PAGES - 1)) begin
					scan_d  = '0;
					state_d = ppa_pkg::S_IDLE;
				end
			end

			// take the next request and dispatch it
			ppa_pkg::S_IDLE: begin
				if (!rq_empty) begin
					rq_pop      = 1'b1;
					cur_d       = rq_head;
					res_page_d  = '0;
					res_stat_d  = ppa_pkg::STAT_OK;
					res_evict_d = 1'b0;
					res_cache_d = 1'b0;
					scan_d      = '0;
					mod_d       = '0;
					vld_d       = 1'b0;
					run_d       = '0;
					state_d     = ppa_pkg::S_RESULT;
					case (rq_head.op)
						ppa_pkg::OP_ADD, ppa_pkg::OP_FREE: begin
							bm_raddr = pidx_t'(rq_head.page);
							state_d  = ppa_pkg::S_PG_CHK;
						end
						ppa_pkg::OP_BUILD: begin
							depth_d = '0;
							state_d = ppa_pkg::S_BUILD;
						end
						ppa_pkg::OP_ALLOC: begin
							res_evict_d = (ext_t'(free_q) <= ext_t'(emergency));
							if (free_q == '0) begin
								res_stat_d = ppa_pkg::STAT_OOM;
							end else if (!ready_q) begin
								state_d = ppa_pkg::S_SCAN;
							end else if (depth_q != '0) begin
								sk_raddr = pidx_t'(depth_q - 1'b1);
								depth_d  = depth_q - 1'b1;
								state_d  = ppa_pkg::S_POP;
							end else begin
								res_stat_d = ppa_pkg::STAT_OOM;
							end
						end
						ppa_pkg::OP_CONTIG: begin
							if (!ready_q) begin
								res_stat_d = ppa_pkg::STAT_NOTREADY;
							end else if (rq_head.page_count == '0 ||
								ext_t'(rq_head.page_count) + ext_t'(emergency)
								>= ext_t'(free_q)) begin
								res_stat_d = ppa_pkg::STAT_NOFIT;
							end else begin
								top_d = (top_raw > ext_t'(NUM_PAGES)) ?
									cnt_t'(NUM_PAGES) : cnt_t'(top_raw);
								state_d = ppa_pkg::S_CSCAN;
							end
						end
						default: begin
							res_stat_d = ppa_pkg::STAT_NOFIT;
						end
					endcase
				end
			end

			// add or free: bitmap bit is now visible
			ppa_pkg::S_PG_CHK: begin
				state_d = ppa_pkg::S_RESULT;
				if (cur_q.oob || bm_rdata) begin
					res_stat_d = ppa_pkg::STAT_BAD;
				end else begin
					bm_we      = 1'b1;
					bm_waddr   = pidx_t'(cur_q.page);
					bm_wdata   = 1'b1;
					free_d     = free_q + 1'b1;
					res_page_d = cur_q.page;
					if (cur_q.op == ppa_pkg::OP_ADD) begin
						known_d = known_q + 1'b1;
						if (pidx_t'(cur_q.page) > high_q) begin
							high_d = pidx_t'(cur_q.page);
						end
					end else begin
						res_cache_d = (ext_t'(free_q) + 1'b1) >
							(ext_t'(emergency) << 1);
					end
					if (ready_q && ext_t'(depth_q) < ext_t'(NUM_PAGES)) begin
						sk_we    = 1'b1;
						sk_waddr = pidx_t'(depth_q);
						sk_wdata = pidx_t'(cur_q.page);
						depth_d  = depth_q + 1'b1;
					end
				end
			end

			// stack top is now visible
			ppa_pkg::S_POP: begin
				bm_we      = 1'b1;
				bm_waddr   = sk_rdata;
				free_d     = free_q - 1'b1;
				res_page_d = ppa_pkg::PAGE_W'(sk_rdata);
				state_d    = ppa_pkg::S_RESULT;
			end

			// lowest free page, before the stack exists
			ppa_pkg::S_SCAN: begin
				issue = (ext_t'(scan_q) < ext_t'(NUM_PAGES));
				if (issue) begin
					bm_raddr = pidx_t'(scan_q);
					scan_d   = scan_q + 1'b1;
				end
				vld_d = issue;
				idx_d = scan_q;
				if (vld_s1 && bm_rdata) begin
					bm_we      = 1'b1;
					bm_waddr   = pidx_t'(idx_s1);
					free_d     = free_q - 1'b1;
					res_page_d = ppa_pkg::PAGE_W'(idx_s1);
					vld_d      = 1'b0;
					state_d    = ppa_pkg::S_RESULT;
				end else if (!issue && !vld_s1) begin
					res_stat_d = ppa_pkg::STAT_OOM;
					state_d    = ppa_pkg::S_RESULT;
				end
			end

			// push every free page in ascending order
			ppa_pkg::S_BUILD: begin
				issue = (ext_t'(scan_q) < ext_t'(NUM_PAGES));
				if (issue) begin
					bm_raddr = pidx_t'(scan_q);
					scan_d   = scan_q + 1'b1;
				end
				vld_d = issue;
				idx_d = scan_q;
				if (vld_s1 && bm_rdata) begin
					sk_we    = 1'b1;
					sk_waddr = pidx_t'(depth_q);
					sk_wdata = pidx_t'(idx_s1);
					depth_d  = depth_q + 1'b1;
				end
				if (!issue && !vld_s1) begin
					ready_d = 1'b1;
					state_d = ppa_pkg::S_RESULT;
				end
			end

			// contiguous search, one page per cycle with a running modulo
			ppa_pkg::S_CSCAN: begin
				issue = (scan_q < top_q);
				if (issue) begin
					bm_raddr = pidx_t'(scan_q);
					scan_d   = scan_q + 1'b1;
					mod_d    = (cur_q.boundary_pages == '0 ||
						mod_q == cur_q.boundary_pages - 1'b1) ? '0 : mod_q + 1'b1;
				end
				vld_d  = issue;
				idx_d  = scan_q;
				mod1_d = mod_q;
				if (vld_s1) begin
					okbit = bm_rdata &&
						(ext_t'(idx_s1) >= ext_t'(cur_q.min_page)) &&
						!(cur_q.boundary_pages != '0 && mod_s1 == '0);
					if (!okbit) begin
						run_d = '0;
					end else if (ext_t'(run_q) + 1'b1 == ext_t'(cur_q.page_count)) begin
						end_d   = pidx_t'(idx_s1);
						start_d = pidx_t'(run_start);
						scan_d  = cnt_t'(run_start);
						vld_d   = 1'b0;
						state_d = ppa_pkg::S_CCLR;
					end else begin
						run_d = run_q + 1'b1;
					end
				end else if (!issue) begin
					res_stat_d = ppa_pkg::STAT_NOFIT;
					state_d    = ppa_pkg::S_RESULT;
				end
			end

			// take the run out of the bitmap
			ppa_pkg::S_CCLR: begin
				bm_we    = 1'b1;
				bm_waddr = pidx_t'(scan_q);
				free_d   = free_q - 1'b1;
				scan_d   = scan_q + 1'b1;
				if (pidx_t'(scan_q) == end_q) begin
					scan_d  = '0;
					wr_d    = '0;
					vld_d   = 1'b0;
					state_d = ppa_pkg::S_CMP;
				end
			end

			// compact the stack, dropping the run's pages in order
			ppa_pkg::S_CMP: begin
				issue = (scan_q < depth_q);
				if (issue) begin
					sk_raddr = pidx_t'(scan_q);
					scan_d   = scan_q + 1'b1;
				end
				vld_d = issue;
				if (vld_s1 && !(sk_rdata >= start_q && sk_rdata <= end_q)) begin
					sk_we    = 1'b1;
					sk_waddr = pidx_t'(wr_q);
					sk_wdata = sk_rdata;
					wr_d     = wr_q + 1'b1;
				end
				if (!issue && !vld_s1) begin
					depth_d    = wr_q;
					res_page_d = ppa_pkg::PAGE_W'(start_q);
					state_d    = ppa_pkg::S_RESULT;
				end
			end

			// hand the result to the output queue
			ppa_pkg::S_RESULT: begin
				if (!out_full) begin
					out_push = 1'b1;
					state_d  = ppa_pkg::S_IDLE;
				end
			end

			default: begin
				state_d = ppa_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ppa_pkg::S_CLEAR;
			cur_q       <= '0;
			scan_q      <= '0;
			vld_s1      <= 1'b0;
			idx_s1      <= '0;
			mod_q       <= '0;
			mod_s1      <= '0;
			run_q       <= '0;
			top_q       <= '0;
			start_q     <= '0;
			end_q       <= '0;
			wr_q        <= '0;
			depth_q     <= '0;
			free_q      <= '0;
			known_q     <= '0;
			high_q      <= '0;
			ready_q     <= 1'b0;
			res_page_q  <= '0;
			res_stat_q  <= ppa_pkg::STAT_OK;
			res_evict_q <= 1'b0;
			res_cache_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cur_q       <= cur_d;
			scan_q      <= scan_d;
			vld_s1      <= vld_d;
			idx_s1      <= idx_d;
			mod_q       <= mod_d;
			mod_s1      <= mod1_d;
			run_q       <= run_d;
			top_q       <= top_d;
			start_q     <= start_d;
			end_q       <= end_d;
			wr_q        <= wr_d;
			depth_q     <= depth_d;
			free_q      <= free_d;
			known_q     <= known_d;
			high_q      <= high_d;
			ready_q     <= ready_d;
			res_page_q  <= res_page_d;
			res_stat_q  <= res_stat_d;
			res_evict_q <= res_evict_d;
			res_cache_q <= res_cache_d;
		end
	end

endmodule

// ===== hw/rtl/physical_page_allocator.sv =====
`timescale 1ns / 1ps
// Channel   | Direction | Handshake                  | Payload
// request   | in        | push / full                | req_type page page_count min_page
//           |           |                            | max_page boundary_pages
// result    | out       | pop / empty                | page_res status evict_request
//           |           |                            | cache_normal free_pages known_pages
// config    | in        | cfg_valid / cfg_ready      | cfg_data (emergency_pages)
//
// Add, free and stack alloc pass the request queue, the dispatch state, one check or pop
// state and the result state. Alloc before build walks the bitmap up to the first free
// page; build walks the whole bitmap; contiguous walks the bitmap up to the top limit,
// clears the run, then compacts the stack, all one page per cycle over bitmap or stack.
// After reset a clearing pass over every bitmap page holds full high.
// Two-entry queues on both sides let requests land while a result waits.
module physical_page_allocator #(
	parameter int NUM_PAGES = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [ppa_pkg::REQ_W-1:0]  req_type,
	input  logic [ppa_pkg::PAGE_W-1:0] page,
	input  logic [ppa_pkg::CNT_W-1:0]  page_count,
	input  logic [ppa_pkg::CNT_W-1:0]  min_page,
	input  logic [ppa_pkg::CNT_W-1:0]  max_page,
	input  logic [ppa_pkg::CNT_W-1:0]  boundary_pages,
	output logic                       empty,
	input  logic                       pop,
	output logic [ppa_pkg::PAGE_W-1:0] page_res,
	output logic [2:0]                 status,
	output logic                       evict_request,
	output logic                       cache_normal,
	output logic [ppa_pkg::CNT_W-1:0]  free_pages,
	output logic [ppa_pkg::CNT_W-1:0]  known_pages,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [ppa_pkg::CNT_W-1:0]  cfg_data
);

	logic [ppa_pkg::CNT_W-1:0]        emergency_q;
	logic                             init_done;
	logic                             rq_pop;
	logic                             rq_empty;
	ppa_pkg::req_t                    rq_head;
	logic                             out_full;
	logic                             out_push;
	ppa_pkg::res_t                    out_data;
	logic [$bits(ppa_pkg::res_t)-1:0] out_rdata;
	ppa_pkg::res_t                    out_head;

	// reserve register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emergency_q <= ppa_pkg::RESERVE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			emergency_q <= cfg_data;
		end
	end

	ppa_front #(.NUM_PAGES(NUM_PAGES)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.req_type      (req_type),
		.page          (page),
		.page_count    (page_count),
		.min_page      (min_page),
		.max_page      (max_page),
		.boundary_pages(boundary_pages),
		.init_done     (init_done),
		.rq_pop        (rq_pop),
		.rq_empty      (rq_empty),
		.rq_head       (rq_head)
	);

	ppa_back #(.NUM_PAGES(NUM_PAGES)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.emergency(emergency_q),
		.rq_empty (rq_empty),
		.rq_head  (rq_head),
		.rq_pop   (rq_pop),
		.out_full (out_full),
		.out_push (out_push),
		.out_data (out_data),
		.init_done(init_done)
	);

	// result queue
	ppa_fifo #(
		.WIDTH($bits(ppa_pkg::res_t)),
		.DEPTH(2)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (out_push),
		.wdata (out_data),
		.full  (out_full),
		.pop   (pop),
		.rdata (out_rdata),
		.empty (empty)
	);

	assign out_head      = out_rdata;
	assign page_res      = out_head.page_res;
	assign status        = out_head.status;
	assign evict_request = out_head.evict_request;
	assign cache_normal  = out_head.cache_normal;
	assign free_pages    = out_head.free_pages;
	assign known_pages   = out_head.known_pages;

endmodule

// ===== hw/rtl/ppa_checker.sv =====
`timescale 1ns / 1ps
module ppa_assertions (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       empty,
	input logic                       pop,
	input logic [ppa_pkg::PAGE_W-1:0] page_res,
	input logic [2:0]                 status,
	input logic                       evict_request,
	input logic                       cache_normal
);

	// failed requests report page zero
	a_fail_page_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != ppa_pkg::STAT_OK) |-> (page_res == '0))
		else $error("failed request carries a nonzero page");

	// cache hint only on a successful transfer
	a_cache_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && cache_normal) |-> (status == ppa_pkg::STAT_OK))
		else $error("cache hint on a failed request");

	// eviction hint only on single allocs, which succeed or run out
	a_evict_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && evict_request) |->
		(!cache_normal && (status == ppa_pkg::STAT_OK || status == ppa_pkg::STAT_OOM)))
		else $error("eviction hint on the wrong kind of result");

	// a waiting result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(page_res) && $stable(status)))
		else $error("waiting result changed");

endmodule

bind physical_page_allocator ppa_assertions u_ppa_assertions (.*);
